@@ design/assert_macros.svh @@
// assertion macros shared by the scatter-add design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock outside reset
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent this cycle, consequent on the next clock
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/fgm_pkg.sv @@
// types, codes and field widths of the global matrix scatter-add
`timescale 1ns / 1ps
`default_nettype none
package fgm_pkg;

  localparam int MODE_W    = 2;
  localparam int NODE_W    = 6;
  localparam int COMP_W    = 2;
  localparam int ENTRY_W   = 32;
  localparam int DOF_W     = 7;
  localparam int DIMS_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 7;
  // global row or column index, node * dims + comp
  localparam int ROW_W     = 8;

  localparam logic [DOF_W-1:0]  DOF_RESET  = 7'd64;
  localparam logic [DIMS_W-1:0] DIMS_RESET = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_DOF_COUNT     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS_PER_NODE = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ACC   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CALC,
    ST_ADDR,
    ST_READ,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic addr;
    logic read;
    logic sweep_start;
    logic sweep_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic sweep_last_all;
    logic sweep_last_half;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ design/fgm_if.sv @@
// valid/ready channels for element entries and results
`timescale 1ns / 1ps
`default_nettype none
interface fgm_in_if;
  import fgm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic                      matrix_sel;
  logic [NODE_W-1:0]         row_node;
  logic [COMP_W-1:0]         row_comp;
  logic [NODE_W-1:0]         col_node;
  logic [COMP_W-1:0]         col_comp;
  logic signed [ENTRY_W-1:0] entry_value;

  modport source (
    output valid, mode, matrix_sel, row_node, row_comp, col_node, col_comp, entry_value,
    input  ready
  );
  modport sink (
    input  valid, mode, matrix_sel, row_node, row_comp, col_node, col_comp, entry_value,
    output ready
  );
endinterface

interface fgm_out_if;
  import fgm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [ENTRY_W-1:0] entry_sum;
  logic                      out_of_range;
  logic                      saturated;

  modport source (
    output valid, entry_sum, out_of_range, saturated,
    input  ready
  );
  modport sink (
    input  valid, entry_sum, out_of_range, saturated,
    output ready
  );
endinterface
`default_nettype wire

@@ design/fem_global_matrix_scatter_add.sv @@
// top level: global mass/stiffness matrix scatter-add
`timescale 1ns / 1ps
`default_nettype none
// Holds two square global matrices (mass, stiffness) in one on-chip memory of
// 2 * 2^clog2(MAX_DOF^2) entries of VALUE_BITS each. An accumulate or read
// transaction steps through the calc, address, read and done states before the
// next acceptance, and its result is registered in the done state once the output
// register is free; the read-modify-write through the single matrix memory
// (row/column calc, address multiply, registered read, write back) sets these steps.
// A clear transaction walks the selected matrix one entry per cycle. After reset
// a clearing pass zeroes both matrices with in_chan.ready low; configuration
// writes are taken meanwhile. The output register lets a new transaction be
// accepted while a result waits.
module fem_global_matrix_scatter_add #(
  parameter int MAX_DOF    = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [fgm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fgm_pkg::CFG_DAT_W-1:0] cfg_wdata,
  fgm_in_if.sink                             in_chan,
  fgm_out_if.source                          out_chan
);
  import fgm_pkg::*;
`include "assert_macros.svh"

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  fgm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fgm_dp #(
    .MAX_DOF    (MAX_DOF),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_mode          (in_chan.mode),
    .in_matrix_sel    (in_chan.matrix_sel),
    .in_row_node      (in_chan.row_node),
    .in_row_comp      (in_chan.row_comp),
    .in_col_node      (in_chan.col_node),
    .in_col_comp      (in_chan.col_comp),
    .in_entry_value   (in_chan.entry_value),
    .cmd              (cmd),
    .sts              (sts),
    .out_ready        (out_chan.ready),
    .out_valid        (out_chan.valid),
    .out_entry_sum    (out_chan.entry_sum),
    .out_out_of_range (out_chan.out_of_range),
    .out_saturated    (out_chan.saturated)
  );

  assign in_chan.ready = in_ready;

  // memory clearing never overlaps taking a new transaction
  `ASSERT_RST(a_sweep_not_ready, clk, rst_n, !(cmd.sweep_step && in_ready), "sweep while ready")
  // a finished transaction shows up on the result channel next cycle
  `ASSERT_NEXT(a_finish_valid, clk, rst_n, cmd.finish, out_chan.valid, "result not presented")
  // rejected addresses leave a zero sum and no saturation
  `ASSERT_RST(a_oor_clean, clk, rst_n,
    !(out_chan.valid && out_chan.out_of_range &&
      (out_chan.saturated || (out_chan.entry_sum != '0))),
    "out-of-range result not clean")

endmodule
`default_nettype wire

@@ design/fgm_ctrl.sv @@
// sequencer for address calc, read-modify-write and matrix clearing
`timescale 1ns / 1ps
`default_nettype none
module fgm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire fgm_pkg::sts_t sts,
  output fgm_pkg::cmd_t      cmd
);
  import fgm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        // zero both matrices after reset
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last_all) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc = 1'b1;
        if (sts.is_clear) begin
          cmd.sweep_start = 1'b1;
          state_nxt       = ST_CLEAR;
        end else begin
          state_nxt = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd.addr  = 1'b1;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_CLEAR: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last_half) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ design/fgm_dp.sv @@
// datapath: config registers, address math, matrix memory, saturating add, output register
`timescale 1ns / 1ps
`default_nettype none
module fgm_dp #(
  parameter int MAX_DOF    = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [fgm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [fgm_pkg::CFG_DAT_W-1:0]      cfg_wdata,
  input  wire logic [fgm_pkg::MODE_W-1:0]         in_mode,
  input  wire logic                               in_matrix_sel,
  input  wire logic [fgm_pkg::NODE_W-1:0]         in_row_node,
  input  wire logic [fgm_pkg::COMP_W-1:0]         in_row_comp,
  input  wire logic [fgm_pkg::NODE_W-1:0]         in_col_node,
  input  wire logic [fgm_pkg::COMP_W-1:0]         in_col_comp,
  input  wire logic signed [fgm_pkg::ENTRY_W-1:0] in_entry_value,
  input  wire fgm_pkg::cmd_t                      cmd,
  output fgm_pkg::sts_t                           sts,
  input  wire logic                               out_ready,
  output logic                                    out_valid,
  output logic signed [fgm_pkg::ENTRY_W-1:0]      out_entry_sum,
  output logic                                    out_out_of_range,
  output logic                                    out_saturated
);
  import fgm_pkg::*;

  localparam int AW      = $clog2(MAX_DOF * MAX_DOF);
  localparam int MW      = AW + 1;
  localparam int DEPTH   = 2 ** MW;
  localparam int PW      = 2 * ROW_W;
  localparam int SUM_W   = (VALUE_BITS > ENTRY_W ? VALUE_BITS : ENTRY_W) + 1;
  localparam int DOF_CAP = MAX_DOF > 127 ? 127 : MAX_DOF;
  localparam logic signed [SUM_W-1:0] ValMax =
    {{(SUM_W - VALUE_BITS + 1){1'b0}}, {(VALUE_BITS - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ValMin = ~ValMax;

  // configuration
  logic [DOF_W-1:0]  dof_count_r;
  logic [DIMS_W-1:0] dims_r;
  logic [DOF_W-1:0]  dof;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dof_count_r <= DOF_RESET;
      dims_r      <= DIMS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DOF_COUNT:     dof_count_r <= cfg_wdata;
        CFG_DIMS_PER_NODE: dims_r      <= cfg_wdata[DIMS_W-1:0];
        default: ;
      endcase
    end
  end

  assign dof = (dof_count_r > DOF_W'(DOF_CAP)) ? DOF_W'(DOF_CAP) : dof_count_r;

  // latched transaction
  mode_t                     mode_r;
  logic                      sel_r;
  logic [NODE_W-1:0]         rn_r, cn_r;
  logic [COMP_W-1:0]         rc_r, cc_r;
  logic signed [ENTRY_W-1:0] val_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode_t'(in_mode);
      sel_r  <= in_matrix_sel;
      rn_r   <= in_row_node;
      rc_r   <= in_row_comp;
      cn_r   <= in_col_node;
      cc_r   <= in_col_comp;
      val_r  <= in_entry_value;
    end
  end

  // global row/column and range check
  logic [ROW_W-1:0] row_c, col_c, row_r, col_r;
  logic             oor_c, oor_r;

  assign row_c = ROW_W'(rn_r) * ROW_W'(dims_r) + ROW_W'(rc_r);
  assign col_c = ROW_W'(cn_r) * ROW_W'(dims_r) + ROW_W'(cc_r);
  assign oor_c = (rc_r >= dims_r) || (cc_r >= dims_r) ||
                 (row_c >= ROW_W'(dof)) || (col_c >= ROW_W'(dof));

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      row_r <= row_c;
      col_r <= col_c;
      oor_r <= oor_c;
    end
  end

  // flat address row * dof + col
  logic [PW-1:0] flat_c;
  logic [AW-1:0] addr_r;

  assign flat_c = PW'(row_r) * PW'(dof) + PW'(col_r);

  always_ff @(posedge clk) begin
    if (cmd.addr) begin
      addr_r <= AW'(flat_c);
    end
  end

  // sweep counter for reset and clear passes
  logic [MW-1:0] sweep_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_cnt_r <= '0;
    end else if (cmd.sweep_start) begin
      sweep_cnt_r <= {sel_r, {AW{1'b0}}};
    end else if (cmd.sweep_step) begin
      sweep_cnt_r <= sweep_cnt_r + 1'b1;
    end
  end

  // saturating add
  logic signed [VALUE_BITS-1:0] rdata_r;
  logic signed [SUM_W-1:0]      old_ext, val_ext, sum_c, res_ext;
  logic signed [VALUE_BITS-1:0] res_c;
  logic                         sat_hi, sat_lo;

  assign old_ext = SUM_W'(rdata_r);
  assign val_ext = SUM_W'(val_r);
  assign sum_c   = old_ext + val_ext;
  assign sat_hi  = sum_c > ValMax;
  assign sat_lo  = sum_c < ValMin;
  assign res_c   = sat_hi ? ValMax[VALUE_BITS-1:0] :
                   sat_lo ? ValMin[VALUE_BITS-1:0] : sum_c[VALUE_BITS-1:0];
  assign res_ext = SUM_W'(res_c);

  logic is_acc, is_read, wr_en;
  logic [MW-1:0]         wr_addr;
  logic [VALUE_BITS-1:0] wr_data;

  assign is_acc  = (mode_r == MODE_ACC);
  assign is_read = (mode_r == MODE_READ);
  assign wr_en   = cmd.sweep_step || (cmd.finish && is_acc && !oor_r);
  assign wr_addr = cmd.sweep_step ? sweep_cnt_r : {sel_r, addr_r};
  assign wr_data = cmd.sweep_step ? '0 : res_c;

  // matrix memory, both matrices, selector in the top address bit
  logic [VALUE_BITS-1:0] mat_mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mat_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rdata_r <= mat_mem[{sel_r, addr_r}];
    end
  end

  // result
  logic signed [ENTRY_W-1:0] sum_out_c;
  logic                      oor_out_c, sat_out_c;

  always_comb begin
    sum_out_c = '0;
    if (!oor_r) begin
      if (is_acc) begin
        sum_out_c = res_ext[ENTRY_W-1:0];
      end else if (is_read) begin
        sum_out_c = old_ext[ENTRY_W-1:0];
      end
    end
  end

  assign oor_out_c = oor_r && (is_acc || is_read);
  assign sat_out_c = is_acc && !oor_r && (sat_hi || sat_lo);

  logic                      out_valid_r;
  logic signed [ENTRY_W-1:0] out_sum_r;
  logic                      out_oor_r, out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_sum_r <= sum_out_c;
      out_oor_r <= oor_out_c;
      out_sat_r <= sat_out_c;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_entry_sum    = out_sum_r;
  assign out_out_of_range = out_oor_r;
  assign out_saturated    = out_sat_r;

  assign sts.is_clear        = (mode_r == MODE_CLEAR);
  assign sts.sweep_last_all  = &sweep_cnt_r;
  assign sts.sweep_last_half = &sweep_cnt_r[AW-1:0];
  assign sts.out_free        = !out_valid_r || out_ready;

endmodule
`default_nettype wire

@@ tb/fgm_scatter_checker.sv @@
// scoreboard for the global matrix scatter-add: mirrors both matrices and checks every result
`timescale 1ns / 1ps
module fgm_scatter_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [fgm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fgm_pkg::CFG_DAT_W-1:0] cfg_wdata,
  fgm_in_if                                  in_mon,
  fgm_out_if                                 out_mon,
  output int                                 fail_count,
  output int                                 results_pending
);
  import fgm_pkg::*;

  localparam int     MAX_DOF     = 64;
  localparam int     MAT_ENTRIES = MAX_DOF * MAX_DOF;
  localparam longint ENTRY_MAX   = 64'sd2147483647;
  localparam longint ENTRY_MIN   = -64'sd2147483648;

  typedef struct packed {
    logic signed [ENTRY_W-1:0] sum;
    logic                      oor;
    logic                      sat;
  } entry_result_t;

  // mass entries first, stiffness entries after
  logic signed [ENTRY_W-1:0] matrix_mem [0:2*MAT_ENTRIES-1];
  logic [DOF_W-1:0]          dof_reg;
  logic [DIMS_W-1:0]         dims_reg;
  entry_result_t             expected_sums [$];

  function automatic entry_result_t scatter_add_predict(
    input mode_t                     op,
    input logic                      sel,
    input logic [NODE_W-1:0]         rn,
    input logic [COMP_W-1:0]         rc,
    input logic [NODE_W-1:0]         cn,
    input logic [COMP_W-1:0]         cc,
    input logic signed [ENTRY_W-1:0] val
  );
    entry_result_t r;
    int            dof;
    int            row;
    int            col;
    int            base;
    int            addr;
    logic          oor;
    longint        acc;
    r    = '0;
    dof  = (int'(dof_reg) > MAX_DOF) ? MAX_DOF : int'(dof_reg);
    row  = int'(rn) * int'(dims_reg) + int'(rc);
    col  = int'(cn) * int'(dims_reg) + int'(cc);
    base = sel ? MAT_ENTRIES : 0;
    // a component beyond dims is rejected even when the flat index would fit
    oor  = (rc >= dims_reg) || (cc >= dims_reg) || (row >= dof) || (col >= dof);
    case (op) inside
      MODE_CLEAR: begin
        for (int i = 0; i < MAT_ENTRIES; i++) matrix_mem[base + i] = '0;
      end
      MODE_ACC, MODE_READ: begin
        if (oor) begin
          r.oor = 1'b1;
        end else begin
          addr = base + row * dof + col;
          if (op == MODE_ACC) begin
            acc = longint'(matrix_mem[addr]) + longint'(val);
            if (acc > ENTRY_MAX) begin
              acc   = ENTRY_MAX;
              r.sat = 1'b1;
            end else if (acc < ENTRY_MIN) begin
              acc   = ENTRY_MIN;
              r.sat = 1'b1;
            end
            matrix_mem[addr] = acc[ENTRY_W-1:0];
          end
          r.sum = matrix_mem[addr];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    entry_result_t got;
    entry_result_t want;
    if (!rst_n) begin
      foreach (matrix_mem[i]) matrix_mem[i] = '0;
      dof_reg  = DOF_RESET;
      dims_reg = DIMS_RESET;
      expected_sums.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.sum = out_mon.entry_sum;
        got.oor = out_mon.out_of_range;
        got.sat = out_mon.saturated;
        if (expected_sums.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result: sum %h oor %b sat %b",
                   $time, got.sum, got.oor, got.sat);
        end else begin
          want = expected_sums.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: result mismatch: expected sum %h oor %b sat %b, got sum %h oor %b sat %b",
                     $time, want.sum, want.oor, want.sat, got.sum, got.oor, got.sat);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_sums.push_back(scatter_add_predict(mode_t'(in_mon.mode), in_mon.matrix_sel,
                                                    in_mon.row_node, in_mon.row_comp,
                                                    in_mon.col_node, in_mon.col_comp,
                                                    in_mon.entry_value));
      // register writes must come only while idle (unenforced) to apply to later transactions
      if (cfg_we) begin
        if (cfg_index == CFG_DOF_COUNT)
          dof_reg = cfg_wdata[DOF_W-1:0];
        else if (cfg_index == CFG_DIMS_PER_NODE)
          dims_reg = cfg_wdata[DIMS_W-1:0];
      end
    end
    results_pending = expected_sums.size();
  end

endmodule

@@ tb/tb_fem_global_matrix_scatter_add.sv @@
// testbench top: drives entry transactions and register writes, reports the verdict
`timescale 1ns / 1ps
module tb_fem_global_matrix_scatter_add;
  import fgm_pkg::*;

  localparam int CLK_PERIOD         = 8;
  localparam int RESET_CYCLES       = 7;
  localparam int LIMIT_CYCLES       = 600_000;
  localparam int RANDOM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE    = 116;
  localparam int HOLD_AFTER_RESULTS = 750;
  localparam int HOLD_OFF_CYCLES    = 150;
  localparam int DRAIN_CYCLES       = 20;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;
  int                   fail_count;
  int                   results_pending;
  int                   send_idle_pct;
  int                   recv_idle_pct;
  int                   dof_now;
  int                   dims_now;

  fgm_in_if  in_chan ();
  fgm_out_if out_chan ();

  fem_global_matrix_scatter_add DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  fgm_scatter_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .fail_count     (fail_count),
    .results_pending(results_pending)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("status: fail");
    $finish;
  end

  // result side: random stalls, plus one long hold-off so the block backs up
  initial begin
    int  taken;
    bit  held;
    taken          = 0;
    held           = 1'b0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_chan.valid && out_chan.ready) taken++;
      @(negedge clk);
      if (!held && taken >= HOLD_AFTER_RESULTS) begin
        held = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        out_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_entry(input mode_t op, input logic sel,
                            input logic [NODE_W-1:0] rn, input logic [COMP_W-1:0] rc,
                            input logic [NODE_W-1:0] cn, input logic [COMP_W-1:0] cc,
                            input logic [ENTRY_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.mode        <= op;
    in_chan.matrix_sel  <= sel;
    in_chan.row_node    <= rn;
    in_chan.row_comp    <= rc;
    in_chan.col_node    <= cn;
    in_chan.col_comp    <= cc;
    in_chan.entry_value <= val;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_entry;
    int                 pick;
    int                 dof_eff;
    int                 span;
    int                 r;
    int                 c;
    mode_t              op;
    logic               sel;
    logic [NODE_W-1:0]  rn;
    logic [COMP_W-1:0]  rc;
    logic [NODE_W-1:0]  cn;
    logic [COMP_W-1:0]  cc;
    logic [ENTRY_W-1:0] val;
    dof_eff = (dof_now > 64) ? 64 : dof_now;
    pick    = $urandom_range(0, 99);
    sel     = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: val = $urandom;
      1: begin
        val = $urandom_range(32'h7fff_ffff, 32'h4000_0000);
        if ($urandom_range(0, 1)) val = -val - 1;
      end
      default: val = $urandom_range(2 * (1 << 20), 0) - (1 << 20);
    endcase
    // mostly a few hot entries so sums build up and clamp
    span = ($urandom_range(0, 2) == 0 || dof_eff < 4) ? dof_eff : 4;
    r    = $urandom_range(0, span - 1);
    c    = $urandom_range(0, span - 1);
    rn   = NODE_W'(r / dims_now);
    rc   = COMP_W'(r % dims_now);
    cn   = NODE_W'(c / dims_now);
    cc   = COMP_W'(c % dims_now);
    if (pick == 0) begin
      op = MODE_CLEAR;
    end else if (pick < 4) begin
      op = MODE_NOP;
    end else if (pick < 12) begin
      op = mode_t'($urandom_range(0, 3));
      if (op == MODE_CLEAR) op = MODE_READ;
      rn = NODE_W'($urandom);
      rc = COMP_W'($urandom);
      cn = NODE_W'($urandom);
      cc = COMP_W'($urandom);
    end else if (pick < 70) begin
      op = MODE_ACC;
    end else begin
      op = MODE_READ;
    end
    send_entry(op, sel, rn, rc, cn, cc, val);
  endtask

  task automatic write_config(input int dof, input int dims);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DOF_COUNT;
    cfg_wdata <= dof[CFG_DAT_W-1:0];
    @(negedge clk);
    cfg_index <= CFG_DIMS_PER_NODE;
    cfg_wdata <= dims[CFG_DAT_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    dof_now  = dof;
    dims_now = dims;
  endtask

  // all results back and the block ready for the next transaction
  task automatic wait_idle;
    in_chan.valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_DOF_COUNT;
    cfg_wdata           = '0;
    in_chan.valid       = 1'b0;
    in_chan.mode        = MODE_NOP;
    in_chan.matrix_sel  = 1'b0;
    in_chan.row_node    = '0;
    in_chan.row_comp    = '0;
    in_chan.col_node    = '0;
    in_chan.col_comp    = '0;
    in_chan.entry_value = '0;
    send_idle_pct       = 18;
    recv_idle_pct       = 76;
    dof_now             = 64;
    dims_now            = 3;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, clamping, rejected addresses, every mode
    write_config(64, 3);
    send_entry(MODE_ACC, 1'b0, 0, 0, 0, 0, 32'h7fff_ffff);
    send_entry(MODE_ACC, 1'b0, 0, 0, 0, 0, 32'h0000_0001);
    send_entry(MODE_ACC, 1'b1, 21, 0, 21, 0, 32'h8000_0000);
    send_entry(MODE_ACC, 1'b1, 21, 0, 21, 0, 32'hffff_ffff);
    send_entry(MODE_READ, 1'b0, 0, 0, 0, 0, 32'h0);
    send_entry(MODE_ACC, 1'b0, 63, 3, 63, 3, 32'hffff_ffff);
    send_entry(MODE_ACC, 1'b0, 22, 0, 0, 0, 32'h0001_0000);
    send_entry(MODE_READ, 1'b1, 0, 0, 21, 1, 32'h0);
    send_entry(MODE_NOP, 1'b1, 63, 3, 63, 3, 32'hffff_ffff);
    send_entry(MODE_ACC, 1'b1, 1, 2, 3, 1, 32'h7fff_ffff);
    send_entry(MODE_ACC, 1'b1, 1, 2, 3, 1, 32'h7fff_ffff);
    send_entry(MODE_CLEAR, 1'b0, 63, 3, 63, 3, 32'hffff_ffff);
    send_entry(MODE_READ, 1'b0, 0, 0, 0, 0, 32'h0);
    send_entry(MODE_READ, 1'b1, 21, 0, 21, 0, 32'h0);
    // side above the maximum, one component: the stored corner keeps its flat address
    wait_idle();
    write_config(127, 1);
    send_entry(MODE_READ, 1'b1, 63, 0, 63, 0, 32'h0);
    send_entry(MODE_ACC, 1'b0, 63, 1, 0, 0, 32'h0001_0000);
    send_entry(MODE_ACC, 1'b0, 5, 0, 7, 0, 32'h0001_0000);
    wait_idle();
    write_config(0, 2);
    send_entry(MODE_READ, 1'b0, 0, 0, 0, 0, 32'h0);
    wait_idle();
    write_config(1, 0);
    send_entry(MODE_ACC, 1'b1, 0, 0, 0, 0, 32'h1234_5678);
    wait_idle();
    write_config(1, 1);
    send_entry(MODE_ACC, 1'b1, 0, 0, 0, 0, 32'h1234_5678);
    send_entry(MODE_CLEAR, 1'b1, 0, 0, 0, 0, 32'h0);
    send_entry(MODE_READ, 1'b1, 0, 0, 0, 0, 32'h0);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      if (phase == 3) begin
        send_idle_pct = 76;
        recv_idle_pct = 18;
      end else if (phase == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        0: write_config(64, 3);
        1: write_config(48, 2);
        2: write_config(127, 3);
        3: write_config(2, 1);
        4: write_config(64, 1);
        5: write_config(17, 3);
        6: write_config(64, 2);
        default: write_config($urandom_range(1, 127), $urandom_range(1, 3));
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random_entry();
    end

    in_chan.valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
